// ===== rtl/core/atp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atp_pkg
// shared constants and types for the accelerometer tilt pipeline
// ----------------------------------------------------------------------------
package atp_pkg;

    localparam int CordicStages = 16;
    localparam int AtanTableLen = 24;
    localparam int NumStages    = (CordicStages < AtanTableLen) ? CordicStages : AtanTableLen;

    // cordic vector width: inputs below 2^40, times 2^14, plus growth
    localparam int VW = 58;
    // fine angle width (1/65536 centidegree)
    localparam int AW = 32;

    // square root: radicand at most 2^47, result below 2^24
    localparam int SqW  = 48;
    localparam int RtW  = 24;

    localparam logic [1:0] RegZeroX = 2'd0;
    localparam logic [1:0] RegZeroY = 2'd1;
    localparam logic [1:0] RegZeroZ = 2'd2;

    localparam logic signed [AW-1:0] RightAngleFine = AW'(64'sd9000 * 64'sd65536);

    function automatic logic signed [AW-1:0] atan_fine(input int i);
        logic signed [AW-1:0] t;
        case (i)
            0: t = 32'sd294912000;  1: t = 32'sd174096719;  2: t = 32'sd91987925;
            3: t = 32'sd46694507;   4: t = 32'sd23437865;   5: t = 32'sd11730358;
            6: t = 32'sd5866610;    7: t = 32'sd2933484;    8: t = 32'sd1466764;
            9: t = 32'sd733385;     10: t = 32'sd366693;    11: t = 32'sd183346;
            12: t = 32'sd91673;     13: t = 32'sd45837;     14: t = 32'sd22918;
            15: t = 32'sd11459;     16: t = 32'sd5730;      17: t = 32'sd2865;
            18: t = 32'sd1432;      19: t = 32'sd716;       20: t = 32'sd358;
            21: t = 32'sd179;       22: t = 32'sd90;        23: t = 32'sd45;
            default: t = '0;
        endcase
        return t;
    endfunction

    // one cordic channel travelling down the cell row
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] ang;
        logic [1:0]           special;   // 0 normal, 1 +90, 2 -90, 3 zero
    } cord_t;

    localparam logic [1:0] SpNone = 2'd0;
    localparam logic [1:0] SpPos  = 2'd1;
    localparam logic [1:0] SpNeg  = 2'd2;
    localparam logic [1:0] SpZero = 2'd3;

    // square root channel
    typedef struct packed {
        logic [SqW-1:0] rem;
        logic [RtW-1:0] root;
    } sqrt_t;

    // side data carried with each sample
    typedef struct packed {
        logic                 fault;
        logic signed [7:0]    temp;
        logic signed [15:0]   y;
        logic signed [15:0]   zy;
    } side_t;

    function automatic logic signed [VW-1:0] shr_tz(input logic signed [VW-1:0] v, input int s);
        logic [VW-1:0] m;
        m = v[VW-1] ? VW'(-v) : v;
        m = m >> s;
        return v[VW-1] ? -$signed(m) : $signed(m);
    endfunction

    // prepare a cordic channel for atan(num/den), den >= 0
    function automatic cord_t cord_init(input logic signed [41:0] num,
                                        input logic signed [41:0] den);
        cord_t c;
        c.x   = VW'(den) <<< 14;
        c.y   = VW'(num) <<< 14;
        c.ang = '0;
        if (den == 0)
            c.special = (num > 0) ? SpPos : ((num < 0) ? SpNeg : SpZero);
        else
            c.special = SpNone;
        return c;
    endfunction

    function automatic logic signed [AW-1:0] cord_angle(input cord_t c);
        logic signed [AW-1:0] a;
        case (c.special)
            SpPos:   a = RightAngleFine;
            SpNeg:   a = -RightAngleFine;
            SpZero:  a = '0;
            default: a = c.ang;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/atp_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atp_sqrt_cell
// one restoring square root step, two radicand bits per cell
// ----------------------------------------------------------------------------
module atp_sqrt_cell
    import atp_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [4:0]     step,
    input  wire logic [SqW-1:0] rad,
    input  wire sqrt_t          din,
    output sqrt_t               dout
);
    logic [5:0]     sh;
    logic [SqW+1:0] trial;
    logic [SqW+1:0] acc;
    sqrt_t          q_next;

    // bring down two bits and try root*4+1
    always_comb
    begin
        sh    = 6'(2 * (RtW - 1 - int'(step)));
        acc   = {din.rem, rad[sh +: 2]};
        trial = {SqW'(din.root), 2'b01};
        if (acc >= trial)
        begin
            q_next.rem  = SqW'(acc - trial);
            q_next.root = {din.root[RtW-2:0], 1'b1};
        end
        else
        begin
            q_next.rem  = SqW'(acc);
            q_next.root = {din.root[RtW-2:0], 1'b0};
        end
    end

    // advance only when the pipe moves
    always_ff @(posedge clk)
    begin
        if (en)
            dout <= q_next;
    end
endmodule
`default_nettype wire

// ===== rtl/core/atp_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atp_cordic_cell
// one vectoring cordic rotation with a fixed shift
// ----------------------------------------------------------------------------
module atp_cordic_cell
    import atp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [4:0] step,
    input  wire cord_t      din,
    output cord_t           dout
);
    cord_t c_next;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    // rotate toward the x axis
    always_comb
    begin
        dx     = shr_tz(din.y, int'(step));
        dy     = shr_tz(din.x, int'(step));
        c_next = din;
        if (din.y >= 0)
        begin
            c_next.x   = din.x + dx;
            c_next.y   = din.y - dy;
            c_next.ang = din.ang + atan_fine(int'(step));
        end
        else
        begin
            c_next.x   = din.x - dx;
            c_next.y   = din.y + dy;
            c_next.ang = din.ang - atan_fine(int'(step));
        end
    end

    // advance only when the pipe moves
    always_ff @(posedge clk)
    begin
        if (en)
            dout <= c_next;
    end
endmodule
`default_nettype wire

// ===== rtl/core/accel_tilt_pitch_roll.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll
// pitch and roll from one accelerometer sample, calibrated against a zero vector
// ----------------------------------------------------------------------------
// One sample is accepted every cycle that the pipe advances, and one result
// leaves per sample, in order. There are 1 + 24 + 16 + 2 = 43 register stages:
// a squaring stage, two 24-cell square root rows (sample and zero), four
// 16-cell cordic rows, one per angle channel (sample pitch, sample roll,
// zero pitch, zero roll), and subtract and round stages.
// The whole pipe advances only when the output register is free or being taken.
// A sample with all three axes at -1 gives bus_fault with zero angles and temp.
module accel_tilt_pitch_roll
    import atp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // raw_x[15:0], raw_y[31:16], raw_z[47:32], temp_byte[55:48]
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pitch_cdeg[15:0], roll_cdeg[31:16], temp_out[39:32]
    output logic [39:0]      m_axis_tdata,
    // bus_fault
    output logic             m_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);
    localparam int Depth = 1 + RtW + NumStages;

    logic adv;
    logic signed [15:0] zx_reg, zy_reg, zz_reg;

    assign cfg_ready = 1'b1;

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zx_reg <= '0;
            zy_reg <= '0;
            zz_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegZeroX: zx_reg <= cfg_data;
                RegZeroY: zy_reg <= cfg_data;
                RegZeroZ: zz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output register frees the pipe
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [15:0] ix, iy, iz;
    assign ix = s_axis_tdata[15:0];
    assign iy = s_axis_tdata[31:16];
    assign iz = s_axis_tdata[47:32];

    // stage 0: squares, pitch channels, side data
    logic  vld_reg [Depth];
    side_t side_reg [Depth];
    logic [SqW-1:0] rs_reg [RtW];   // radicand travels with the root row
    logic [SqW-1:0] rz_reg [RtW];
    cord_t ps_reg [RtW+1];
    cord_t pz_reg [RtW+1];
    logic signed [15:0] ys_hold;

    function automatic cord_t pitch_init(input logic signed [15:0] x,
                                         input logic signed [15:0] z);
        logic signed [41:0] n, d;
        if (z < 0)
        begin
            n = 42'(x) * 256;
            d = -42'(z) * 256;
        end
        else
        begin
            n = -42'(x) * 256;
            d = 42'(z) * 256;
        end
        return cord_init(n, d);
    endfunction

    function automatic logic [SqW-1:0] sq_sum(input logic signed [15:0] x,
                                              input logic signed [15:0] z);
        logic [32:0] s;
        s = 33'($signed(x) * $signed(x)) + 33'($signed(z) * $signed(z));
        return {SqW'(s) << 16};
    endfunction

    // valid bits down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Depth; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < Depth; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // sample data, radicands and pitch channels down the pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].fault <= (ix == -16'sd1) && (iy == -16'sd1) && (iz == -16'sd1);
            side_reg[0].temp  <= s_axis_tdata[55:48];
            side_reg[0].y     <= iy;
            side_reg[0].zy    <= zy_reg;
            rs_reg[0] <= sq_sum(ix, iz);
            rz_reg[0] <= sq_sum(zx_reg, zz_reg);
            ps_reg[0] <= pitch_init(ix, iz);
            pz_reg[0] <= pitch_init(zx_reg, zz_reg);
            for (int i = 1; i < Depth; i++)
                side_reg[i] <= side_reg[i-1];
            for (int i = 1; i < RtW; i++)
            begin
                rs_reg[i] <= rs_reg[i-1];
                rz_reg[i] <= rz_reg[i-1];
            end
            for (int i = 1; i <= RtW; i++)
            begin
                ps_reg[i] <= ps_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
            end
        end
    end

    // square root cell rows
    sqrt_t sqs [RtW+1];
    sqrt_t sqz [RtW+1];
    assign sqs[0] = '0;
    assign sqz[0] = '0;

    genvar g;
    generate
        for (g = 0; g < RtW; g++)
        begin : g_sqrt
            atp_sqrt_cell u_s (.clk(clk), .en(adv), .step(5'(g)), .rad(rs_reg[g]),
                               .din(sqs[g]), .dout(sqs[g+1]));
            atp_sqrt_cell u_z (.clk(clk), .en(adv), .step(5'(g)), .rad(rz_reg[g]),
                               .din(sqz[g]), .dout(sqz[g+1]));
        end
    endgenerate

    assign ys_hold = side_reg[RtW].y;

    // cordic cell rows, four channels
    cord_t cc [4][NumStages+1];
    assign cc[0][0] = ps_reg[RtW];
    assign cc[1][0] = pz_reg[RtW];
    assign cc[2][0] = cord_init(42'(ys_hold) * 256, 42'(sqs[RtW].root));
    assign cc[3][0] = cord_init(42'(side_reg[RtW].zy) * 256, 42'(sqz[RtW].root));

    genvar k;
    generate
        for (k = 0; k < 4; k++)
        begin : g_ch
            for (g = 0; g < NumStages; g++)
            begin : g_st
                atp_cordic_cell u_c (.clk(clk), .en(adv), .step(5'(g)),
                                     .din(cc[k][g]), .dout(cc[k][g+1]));
            end
        end
    endgenerate

    // subtract zero angles
    logic signed [AW:0] pd_reg, rd_reg;
    logic               sd_vld_reg;
    logic               sd_fault_reg;
    logic signed [7:0]  sd_temp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sd_vld_reg <= 1'b0;
        else if (adv)
            sd_vld_reg <= vld_reg[Depth-1];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pd_reg <= (AW+1)'(cord_angle(cc[0][NumStages]))
                      - (AW+1)'(cord_angle(cc[1][NumStages]));
            rd_reg <= (AW+1)'(cord_angle(cc[2][NumStages]))
                      - (AW+1)'(cord_angle(cc[3][NumStages]));
            sd_fault_reg <= side_reg[Depth-1].fault;
            sd_temp_reg  <= side_reg[Depth-1].temp;
        end
    end

    // round to centidegrees, halves away from zero
    function automatic logic signed [15:0] to_cdeg(input logic signed [AW:0] f);
        logic [AW:0] m;
        logic [AW:0] r;
        m = f[AW] ? (AW+1)'(-f) : f;
        r = (m + (AW+1)'(32768)) >> 16;
        return f[AW] ? -$signed(16'(r)) : $signed(16'(r));
    endfunction

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (adv)
            m_axis_tvalid <= sd_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_axis_tuser <= sd_fault_reg;
            if (sd_fault_reg)
                m_axis_tdata <= '0;
            else
                m_axis_tdata <= {sd_temp_reg, to_cdeg(rd_reg), to_cdeg(pd_reg)};
        end
    end
endmodule
`default_nettype wire

// ===== verif/accel_tilt_pitch_roll_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_tb
// checks tilt angles, temperature pass-through and bus fault flag
// ----------------------------------------------------------------------------
// Samples are streamed under several calibration zero vectors, extremes
// included. A bit-exact software model of the vectoring cordic predicts each
// result, and every output transaction is compared in order with it.
// Both stream sides idle at random, and one long output stall fills the pipe.
module accel_tilt_pitch_roll_tb;
    import atp_pkg::*;

    typedef struct {
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [7:0]  temp;
        logic        fault;
    } tilt_t;

    class tilt_scoreboard;
        tilt_t   pending[$];
        longint  cal_x, cal_y, cal_z;
        int      errors;

        function longint shift_tz(longint v, int s);
            longint unsigned m;
            m = (v < 0) ? longint'(-v) : v;
            m = m >> s;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // atan(num/den) in 1/65536 centidegree, den >= 0
        function longint atan_fine_of(longint num, longint den);
            longint vx, vy, ang, dx, dy;
            ang = 0;
            if (den == 0)
                return (num > 0) ? 64'sd589824000 : ((num < 0) ? -64'sd589824000 : 0);
            vx = den * 16384;
            vy = num * 16384;
            for (int i = 0; i < NumStages; i++)
            begin
                dx = shift_tz(vy, i);
                dy = shift_tz(vx, i);
                if (vy >= 0)
                begin
                    vx += dx; vy -= dy; ang += longint'(atan_fine(i));
                end
                else
                begin
                    vx -= dx; vy += dy; ang -= longint'(atan_fine(i));
                end
            end
            return ang;
        endfunction

        function longint pitch_of(longint x, longint z);
            if (z < 0)
                return atan_fine_of(x * 256, -z * 256);
            return atan_fine_of(-x * 256, z * 256);
        endfunction

        function longint roll_of(longint x, longint y, longint z);
            longint unsigned sq;
            sq = longint'(x * x) + longint'(z * z);
            return atan_fine_of(y * 256, longint'(int_sqrt(sq << 16)));
        endfunction

        function longint round_cdeg(longint f);
            if (f < 0)
                return -longint'((longint'(-f) + 32768) >>> 16);
            return (f + 32768) >>> 16;
        endfunction

        // predict the result of one accepted sample
        function void note(logic [55:0] d);
            tilt_t  e;
            longint x, y, z;
            x = longint'($signed(d[15:0]));
            y = longint'($signed(d[31:16]));
            z = longint'($signed(d[47:32]));
            if (x == -1 && y == -1 && z == -1)
            begin
                e.pitch = '0; e.roll = '0; e.temp = '0; e.fault = 1'b1;
            end
            else
            begin
                e.pitch = 16'(round_cdeg(pitch_of(x, z) - pitch_of(cal_x, cal_z)));
                e.roll  = 16'(round_cdeg(roll_of(x, y, z) - roll_of(cal_x, cal_y, cal_z)));
                e.temp  = d[55:48];
                e.fault = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check(logic [39:0] d, logic f);
            tilt_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result data=%h fault=%b", d, f);
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.pitch || d[31:16] !== e.roll || d[39:32] !== e.temp
                || f !== e.fault)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp p=%0d r=%0d t=%0d f=%b got p=%0d r=%0d t=%0d f=%b",
                             $signed(e.pitch), $signed(e.roll), $signed(e.temp), e.fault,
                             $signed(d[15:0]), $signed(d[31:16]), $signed(d[39:32]), f);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;

    tilt_scoreboard sb;
    int snd_idle;
    int rcv_idle;
    int hold_left;

    accel_tilt_pitch_roll DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: check each output transaction, then pick next ready
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check(m_axis_tdata, m_axis_tuser);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input logic [7:0] t);
        while ($urandom_range(99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, z, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note({t, z, y, x});
    endtask

    // caller drops cfg_valid after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            RegZeroX: sb.cal_x = longint'($signed(val));
            RegZeroY: sb.cal_y = longint'($signed(val));
            default:  sb.cal_z = longint'($signed(val));
        endcase
    endtask

    // wait until the pipe has drained
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic random_sample();
        logic [15:0] x, y, z;
        int kind;
        kind = $urandom_range(99);
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        if (kind < 25)
        begin
            // small magnitudes hit zero denominators often
            x = 16'($signed($urandom_range(8)) - 4);
            y = 16'($signed($urandom_range(8)) - 4);
            z = 16'($signed($urandom_range(8)) - 4);
        end
        else if (kind < 35)
            z = '0;
        else if (kind < 40)
        begin
            x = '0; z = '0;
        end
        else if (kind < 45)
        begin
            x = 16'hFFFF; y = 16'hFFFF; z = 16'hFFFF;
        end
        else if (kind < 50)
        begin
            x = 16'($signed($urandom_range(600)) - 300);
            z = 16'($signed($urandom_range(600)) - 300);
        end
        send_sample(x, y, z, 8'($urandom));
    endtask

    // stimulus
    initial
    begin
        logic [15:0] cal [6][3];
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = RegZeroX;
        cfg_data = '0;
        hold_left = 0;
        snd_idle = 22;
        rcv_idle = 88;
        cal[0] = '{16'd0, 16'd0, 16'd0};
        cal[1] = '{16'h8000, 16'h7FFF, 16'h8000};
        cal[2] = '{16'h7FFF, 16'h8000, 16'h7FFF};
        cal[3] = '{16'd25, 16'hFFF0, 16'd0};
        cal[4] = '{16'($urandom), 16'($urandom), 16'($urandom)};
        cal[5] = '{16'd0, 16'd0, 16'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 6; p++)
        begin
            snd_idle = (p < 2) ? 22 : ((p < 4) ? 88 : 0);
            rcv_idle = (p < 2) ? 88 : ((p < 4) ? 22 : 0);
            write_reg(RegZeroX, cal[p][0]);
            write_reg(RegZeroY, cal[p][1]);
            write_reg(RegZeroZ, cal[p][2]);
            cfg_valid <= 1'b0;
            if (p == 0 || p == 1)
            begin
                // directed corners
                send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h7F);
                send_sample(16'h8000, 16'h8000, 16'h8000, 8'h80);
                send_sample(16'd0, 16'd0, 16'd0, 8'd1);
                send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h7F);
                send_sample(16'hFFFF, 16'hFFFF, 16'hFFFE, 8'h55);
                send_sample(16'd0, 16'd5, 16'd0, 8'd2);
                send_sample(16'd0, 16'hFFFB, 16'd0, 8'd3);
                send_sample(16'd5, 16'd0, 16'd0, 8'd4);
                send_sample(16'hFFFB, 16'd3, 16'd0, 8'd5);
                send_sample(16'd0, 16'd0, 16'hFFF9, 8'd6);
                send_sample(16'hFFFF, 16'hFFFF, 16'd0, 8'd7);
                send_sample(16'd1, 16'h8000, 16'hFFFF, 8'hAA);
                send_sample(16'h7FFF, 16'd0, 16'h8000, 8'h80);
                send_sample(16'h8000, 16'h7FFF, 16'd1, 8'h00);
                send_sample(16'd100, 16'd100, 16'd100, 8'hFF);
            end
            if (p == 2)
            begin
                // long output stall while samples keep coming at full rate
                snd_idle = 0;
                hold_left = 300;
                repeat (120) send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                                         8'($urandom));
                snd_idle = 88;
            end
            repeat (280) random_sample();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
